// ===== hdl/avsd_pkg.sv =====
// ----------------------------------------------------------------------------
// avsd_pkg
// Shared types and constants of the audio/video stream demultiplexer.
// ----------------------------------------------------------------------------
package avsd_pkg;

  // Audio ring geometry
  localparam int AUDIO_DEPTH = 256;
  localparam int PTR_W       = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;

  // Reset value of the run length register
  localparam logic [BYTE_W-1:0] RUN_LENGTH_RESET = 8'd14;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_STREAM  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Result kinds
  localparam logic KIND_VIDEO = 1'b0;
  localparam logic KIND_AUDIO = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hdl/avsd_ifs.sv =====
// ----------------------------------------------------------------------------
// avsd_ifs
// Valid/ready channel interfaces: input words, result words, config writes.
// ----------------------------------------------------------------------------
interface avsd_in_if import avsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  byte_t             stream_byte;

  modport source (output valid, output func, output stream_byte, input ready);
  modport sink   (input valid, input func, input stream_byte, output ready);
endinterface

interface avsd_out_if import avsd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  out_kind;
  byte_t out_value;

  modport source (output valid, output out_kind, output out_value, input ready);
  modport sink   (input valid, input out_kind, input out_value, output ready);
endinterface

interface avsd_cfg_if import avsd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t video_run_length;

  modport source (output valid, output video_run_length, input ready);
  modport sink   (input valid, input video_run_length, output ready);
endinterface

// ===== hdl/avsd_ram.sv =====
// ----------------------------------------------------------------------------
// avsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module avsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/av_stream_demux_unit.sv =====
// ----------------------------------------------------------------------------
// av_stream_demux_unit
// Splits an interleaved video/audio byte stream into display and audio words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one word per stream byte (func 0), audio sample tick (func 1)
//             or clip restart (func 2). func 3 is ignored.
//   out_ch  : display bytes (out_kind 0) and audio samples (out_kind 1).
//   cfg_ch  : writes video_run_length; always ready, write only when idle.
// A stream byte is passed as a display word until the phase counter reaches
// video_run_length; the next byte goes into the audio ring and gives no word.
// A tick reads the ring at the read pointer; entries never written read zero.
// Throughput: one input word per cycle, sustained while in_ch.ready stays high.
// An accepted word passes through the read stage, which takes the registered
// ring read, and then through the output register before it shows on out_ch.
// The ring lives in one RAM read at one port; a fill flag and the write
// pointer mark which entries were written, so reset needs no clearing pass
// and the block is ready the cycle after reset.
// When out_ch stalls, the output register holds its word and one more word
// waits in the read stage; in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module av_stream_demux_unit import avsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  avsd_in_if.sink    in_ch,
  avsd_out_if.source out_ch,
  avsd_cfg_if.sink   cfg_ch
);

  // State
  byte_t run_len_r;
  byte_t phase_r, phase_nxt;
  ptr_t  wr_ptr_r, wr_ptr_nxt;
  ptr_t  rd_ptr_r, rd_ptr_nxt;
  logic  wrapped_r, wrapped_nxt;

  // Read stage
  logic  s1_v_r, s1_v_nxt;
  logic  s1_kind_r;
  byte_t s1_byte_r;
  logic  s1_zero_r;

  // Output register
  logic  s2_v_r, s2_v_nxt;
  logic  s2_kind_r;
  byte_t s2_value_r;

  logic  in_acc, s1_adv, s2_load;
  logic  is_stream, is_tick, hit, has_result;
  logic  ram_we, ram_re;
  byte_t ram_q;
  byte_t s1_value;

  // Config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= RUN_LENGTH_RESET;
    end else if (cfg_ch.valid) begin
      run_len_r <= cfg_ch.video_run_length;
    end
  end

  // Handshake and decode
  assign s2_load    = !s2_v_r || out_ch.ready;
  assign s1_adv     = !s1_v_r || s2_load;
  assign in_ch.ready = s1_adv;
  assign in_acc     = in_ch.valid && s1_adv;

  assign is_stream  = (in_ch.func == FUNC_STREAM);
  assign is_tick    = (in_ch.func == FUNC_TICK);
  assign hit        = (phase_r == run_len_r);
  assign has_result = is_tick || (is_stream && !hit);

  assign ram_we = in_acc && is_stream && hit;
  assign ram_re = in_acc && is_tick;

  // Counter and pointer updates
  always_comb begin
    phase_nxt   = phase_r;
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    wrapped_nxt = wrapped_r;
    if (in_acc) begin
      case (in_ch.func)
        FUNC_STREAM: begin
          if (hit) begin
            phase_nxt = '0;
            if (wr_ptr_r == ptr_t'(AUDIO_DEPTH - 1)) begin
              wr_ptr_nxt  = '0;
              wrapped_nxt = 1'b1;
            end else begin
              wr_ptr_nxt = wr_ptr_r + 1'b1;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
        FUNC_TICK: begin
          if (rd_ptr_r == ptr_t'(AUDIO_DEPTH - 1)) begin
            rd_ptr_nxt = '0;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
        end
        FUNC_RESTART: begin
          phase_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      wrapped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // Audio ring
  avsd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (AUDIO_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_ch.stream_byte),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  // Read stage: holds the word while the RAM data settles
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_adv) begin
      s1_v_nxt = in_acc && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= is_tick ? KIND_AUDIO : KIND_VIDEO;
      s1_byte_r <= in_ch.stream_byte;
      // entry not yet written since reset reads as zero
      s1_zero_r <= !(wrapped_r || (rd_ptr_r < wr_ptr_r));
    end
  end

  always_comb begin
    if (s1_kind_r == KIND_AUDIO) begin
      s1_value = s1_zero_r ? '0 : ram_q;
    end else begin
      s1_value = s1_byte_r;
    end
  end

  // Output register
  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_v_r) begin
      s2_kind_r  <= s1_kind_r;
      s2_value_r <= s1_value;
    end
  end

  assign out_ch.valid     = s2_v_r;
  assign out_ch.out_kind  = s2_kind_r;
  assign out_ch.out_value = s2_value_r;

  // Checks
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (s1_v_r == $past(has_result)))
    else $error("read stage fill does not match accepted word");

  a_store_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (phase_r == '0))
    else $error("phase counter not cleared after audio store");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("ring fill flag dropped");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_load) |=> s2_v_r)
    else $error("word lost between read stage and output register");

endmodule
